>>> sv/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

>>> sv/vdhi_pkg.sv
// ----------------------------------------------------------------------------
// vdhi_pkg
// shared constants and types of the vertex dedup hash indexer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package vdhi_pkg;
  localparam int VERTEX_CAPACITY = 16384;
  localparam int HASH_BUCKETS    = 4096;
  localparam int VIW = $clog2(VERTEX_CAPACITY);
  localparam int BKW = $clog2(HASH_BUCKETS);
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_BATCH = 1'b1;
  localparam int VW = 64 + 32 + 64 + 48 + 64 + 4;

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_MUL, S_BREAD, S_BWAIT, S_EREAD, S_EWAIT, S_CMP,
    S_APPEND, S_CLEAR, S_OUT
  } state_t;
endpackage
`default_nettype wire

>>> sv/vertex_dedup_hash_indexer.sv
// batch op clears one bucket per cycle, then returns a result; add op hashes the key,
//   reads the bucket head, compares each chain link, then appends, hits or reports full
// one transfer at a time, next input accepted once the result leaves
// the shared 32x32 multiplier is used once per hash word; one store read per link
// reset: synchronous, clears control state and runs a clearing pass over all
//   4096 buckets during which no input is accepted
// ----------------------------------------------------------------------------
// vertex_dedup_hash_indexer
// chained hash table over a vertex store, returns the index of each vertex
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vertex_dedup_hash_indexer (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic op,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic [63:0] color_rgba,
  input  wire logic signed [15:0] normal_x,
  input  wire logic signed [15:0] normal_y,
  input  wire logic signed [15:0] normal_z,
  input  wire logic signed [31:0] tex_u,
  input  wire logic signed [31:0] tex_v,
  input  wire logic [3:0] tex_slot,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic [13:0] vertex_index,
  output logic      is_new,
  output logic      store_full
);
  import vdhi_pkg::*;

  // memories
  logic [VW-1:0]  vert_mem [VERTEX_CAPACITY];
  logic [VIW:0]   link_mem [VERTEX_CAPACITY];   // link valid above index
  logic [VIW:0]   head_mem [HASH_BUCKETS];      // bucket valid above head

  state_t state, state_next;
  logic [VW-1:0] key;           // packed vertex being looked up
  logic [31:0]   hash, prod;
  logic [3:0]    word_cnt;
  logic [BKW-1:0] clr_addr;
  logic [VIW:0]  count;         // vertex count, can reach capacity
  logic [VIW:0]  head;          // head entry of the bucket
  logic [VIW-1:0] cur;
  logic [VW-1:0] vert_rd;
  logic [VIW:0]  link_rd, head_rd;
  logic [13:0]   res_index;
  logic          res_new, res_full;
  logic          booted;

  wire logic [BKW-1:0] bucket = hash[BKW-1:0];

  // hash word select, 16-bit fields sign extended and the slot zero extended to 32 bits
  logic [31:0] word;
  always_comb begin
    case (word_cnt)
      4'd0:  word = key[31:0];
      4'd1:  word = key[63:32];
      4'd2:  word = key[95:64];
      4'd3:  word = {{16{key[111]}}, key[111:96]};
      4'd4:  word = {{16{key[127]}}, key[127:112]};
      4'd5:  word = {{16{key[143]}}, key[143:128]};
      4'd6:  word = {{16{key[159]}}, key[159:144]};
      4'd7:  word = {{16{key[175]}}, key[175:160]};
      4'd8:  word = {{16{key[191]}}, key[191:176]};
      4'd9:  word = {{16{key[207]}}, key[207:192]};
      4'd10: word = key[239:208];
      4'd11: word = key[271:240];
      default: word = {28'd0, key[275:272]};
    endcase
  end

  // memory ports, read data registered
  always_ff @(posedge clk) begin
    vert_rd <= vert_mem[cur];
    link_rd <= link_mem[cur];
    head_rd <= head_mem[bucket];
    if (state == S_APPEND && count != (VIW+1)'(VERTEX_CAPACITY)) begin
      vert_mem[count[VIW-1:0]] <= key;
      link_mem[count[VIW-1:0]] <= head;
    end
    if (state == S_CLEAR)
      head_mem[clr_addr] <= '0;
    else if (state == S_APPEND && count != (VIW+1)'(VERTEX_CAPACITY))
      head_mem[bucket] <= {1'b1, count[VIW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (in_valid) begin
          key <= {tex_slot, tex_v, tex_u, normal_z, normal_y, normal_x,
                  color_rgba, pos_z, pos_y, pos_x};
          hash <= FNV_BASIS;
          word_cnt <= '0;
          clr_addr <= '0;
        end
        S_HASH: prod <= hash ^ word;
        S_MUL: begin
          hash <= prod * FNV_PRIME;   // shared multiplier
          word_cnt <= word_cnt + 4'd1;
        end
        S_BWAIT: begin
          head <= head_rd;
          cur <= head_rd[VIW-1:0];
        end
        S_CMP: if (vert_rd == key) begin
          res_index <= 14'(cur); res_new <= 1'b0; res_full <= 1'b0;
        end else if (link_rd[VIW]) cur <= link_rd[VIW-1:0];
        S_APPEND: begin
          if (count == (VIW+1)'(VERTEX_CAPACITY)) begin
            res_index <= '0; res_new <= 1'b0; res_full <= 1'b1;
          end else begin
            res_index <= 14'(count); res_new <= 1'b1; res_full <= 1'b0;
            count <= count + 1'b1;
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          count <= '0;
          res_index <= '0; res_new <= 1'b0; res_full <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = (op == OP_BATCH) ? S_CLEAR : S_HASH;
      end
      S_HASH: state_next = S_MUL;
      S_MUL: state_next = (word_cnt == 4'd12) ? S_BREAD : S_HASH;
      S_BREAD: state_next = S_BWAIT;
      S_BWAIT: state_next = head_rd[VIW] ? S_EREAD : S_APPEND;
      S_EREAD: state_next = S_EWAIT;
      S_EWAIT: state_next = S_CMP;
      S_CMP: begin
        if (vert_rd == key) state_next = S_OUT;
        else if (link_rd[VIW]) state_next = S_EREAD;
        else state_next = S_APPEND;
      end
      S_APPEND: state_next = S_OUT;
      S_CLEAR: if (clr_addr == BKW'(HASH_BUCKETS - 1))
        state_next = booted ? S_OUT : S_IDLE;
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // a batch clear during reset must not emit a result
  always_ff @(posedge clk) begin
    if (rst) booted <= 1'b0;
    else if (state == S_IDLE) booted <= 1'b1;
  end

  assign vertex_index = res_index;
  assign is_new = res_new;
  assign store_full = res_full;
endmodule
`default_nettype wire

>>> sv/vdhi_checker.sv
// ----------------------------------------------------------------------------
// vdhi_checker
// port level checks of the vertex dedup hash indexer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vdhi_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [13:0] vertex_index,
  input wire logic is_new,
  input wire logic store_full
);
  `ASSERT_IMP(a_flags, clk, rst, out_valid, !(is_new && store_full))
  `ASSERT_IMP(a_full_idx, clk, rst, out_valid && store_full, vertex_index == 14'd0)
  `ASSERT_IMP(a_no_overlap, clk, rst, out_valid, in_stall)
  `ASSERT_NXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(vertex_index))
  `ASSERT_NXT(a_busy, clk, rst, in_valid && !in_stall, in_stall)
endmodule
bind vertex_dedup_hash_indexer vdhi_checker u_chk (.*);
`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// vertex dedup hash indexer testbench
// drives add-vertex and start-batch transfers with random idling and stalls,
// predicts the returned index, new flag and full flag with a local hash table
// model, and compares every result transfer in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import vdhi_pkg::*;

  localparam int CAP = VERTEX_CAPACITY;
  localparam int NBK = HASH_BUCKETS;
  localparam longint LIMIT = 3000000;

  logic clk, rst;
  logic in_valid, in_stall;
  logic op;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [63:0] color_rgba;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic signed [31:0] tex_u, tex_v;
  logic [3:0] tex_slot;
  logic out_valid, out_stall;
  logic [13:0] vertex_index;
  logic is_new, store_full;

  vertex_dedup_hash_indexer dut (.*);

  // one vertex as its packed key of thirteen words
  typedef struct packed {
    logic [31:0] px, py, pz;
    logic [63:0] col;
    logic [15:0] nx, ny, nz;
    logic [31:0] tu, tv;
    logic [3:0] slot;
  } vtx_t;

  typedef struct packed {
    logic [13:0] idx;
    logic nw;
    logic full;
  } index_result_t;

  // local copy of the hash table
  bit bkt_used [NBK];
  int bkt_head [NBK];
  int chain_next [CAP];
  vtx_t verts [CAP];
  int nverts;

  index_result_t expected_q[$];
  vtx_t seen_q[$];
  int errors = 0, n_sent = 0, n_checked = 0, n_new = 0, n_full = 0, n_hit = 0;
  longint cycles = 0;
  int idle_pct = 28;
  int stall_pct = 28;
  bit hold_out = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout at %0t", $time);
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // fnv-1a over the thirteen words (16-bit fields sign extended), masked to a bucket
  function automatic int bucket_of(vtx_t v);
    logic [31:0] w[13];
    logic [31:0] h;
    w[0] = v.px; w[1] = v.py; w[2] = v.pz;
    for (int k = 0; k < 4; k++) w[3+k] = sx16(v.col[16*k +: 16]);
    w[7] = sx16(v.nx); w[8] = sx16(v.ny); w[9] = sx16(v.nz);
    w[10] = v.tu; w[11] = v.tv; w[12] = {28'd0, v.slot};
    h = FNV_BASIS;
    foreach (w[k]) h = (h ^ w[k]) * FNV_PRIME;
    return int'(h & (NBK - 1));
  endfunction

  function automatic index_result_t lookup_or_insert(logic o, vtx_t v);
    index_result_t r;
    int b, cur;
    r = '0;
    if (o == OP_BATCH) begin
      foreach (bkt_used[i]) bkt_used[i] = 0;
      nverts = 0;
      return r;
    end
    b = bucket_of(v);
    cur = bkt_used[b] ? bkt_head[b] : -1;
    while (cur >= 0) begin
      if (verts[cur] == v) begin
        r.idx = 14'(cur);
        n_hit++;
        return r;
      end
      cur = chain_next[cur];
    end
    if (nverts >= CAP) begin
      r.full = 1;
      n_full++;
      return r;
    end
    verts[nverts] = v;
    chain_next[nverts] = bkt_used[b] ? bkt_head[b] : -1;
    bkt_head[b] = nverts;
    bkt_used[b] = 1;
    r.idx = 14'(nverts);
    r.nw = 1;
    n_new++;
    nverts++;
    return r;
  endfunction

  // send one transfer; inputs change on the falling edge
  task automatic send_item(logic o, vtx_t v);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 0;
    end
    @(negedge clk);
    in_valid <= 1;
    op <= o;
    {pos_x, pos_y, pos_z} <= {v.px, v.py, v.pz};
    color_rgba <= v.col;
    {normal_x, normal_y, normal_z} <= {v.nx, v.ny, v.nz};
    {tex_u, tex_v} <= {v.tu, v.tv};
    tex_slot <= v.slot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(lookup_or_insert(o, v));
    if (o != OP_BATCH) seen_q.push_back(v);
    n_sent++;
    @(negedge clk);
    in_valid <= 0;
  endtask

  function automatic vtx_t rand_vtx();
    vtx_t v;
    v.px = $urandom; v.py = $urandom; v.pz = $urandom;
    v.col = {$urandom, $urandom};
    v.nx = 16'($urandom); v.ny = 16'($urandom); v.nz = 16'($urandom);
    v.tu = $urandom; v.tv = $urandom;
    v.slot = 4'($urandom);
    return v;
  endfunction

  // a vertex from a small alphabet so repeats and collisions are common
  function automatic vtx_t mesh_vtx();
    vtx_t v;
    v = '0;
    v.px = $urandom_range(7) * 1000;
    v.py = -$urandom_range(3) * 500;
    v.pz = $urandom_range(1);
    v.col = {4{16'($urandom_range(1) ? 16'h8000 : 16'h03e8)}};
    v.nx = $urandom_range(1) ? -16'sd1000 : 16'sd1000;
    v.tu = $urandom_range(2);
    v.slot = 4'($urandom_range(15));
    return v;
  endfunction

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // result checker: sample at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result idx %0d", $time, vertex_index);
        errors++;
      end else begin
        index_result_t e;
        e = expected_q.pop_front();
        n_checked++;
        if (vertex_index !== e.idx) begin
          $display("%0t: vertex_index exp %0d got %0d", $time, e.idx, vertex_index);
          errors++;
        end
        if (is_new !== e.nw) begin
          $display("%0t: is_new exp %0b got %0b", $time, e.nw, is_new);
          errors++;
        end
        if (store_full !== e.full) begin
          $display("%0t: store_full exp %0b got %0b", $time, e.full, store_full);
          errors++;
        end
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_out) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic test_directed();
    vtx_t v;
    v = '0;
    send_item(OP_ADD, v);
    send_item(OP_ADD, v);                 // exact repeat hits
    v = '1;
    send_item(OP_ADD, v);
    v = '0;
    v.px = 32'h8000_0000; v.py = 32'h7fff_ffff; v.col = 64'h8000_7fff_8000_7fff;
    v.nx = 16'h8000; v.ny = 16'h7fff; v.tu = 32'h8000_0000; v.tv = 32'h7fff_ffff;
    send_item(OP_ADD, v);
    v.slot = 1;                           // differs only in slot
    send_item(OP_ADD, v);
    v.slot = 15;
    send_item(OP_ADD, v);
    send_item(OP_ADD, v);
    v = '0;
    send_item(OP_ADD, v);
    send_item(OP_BATCH, rand_vtx());      // vertex fields ignored
    send_item(OP_ADD, v);                 // index restarts at zero
    send_item(OP_BATCH, '0);
    for (int i = 0; i < 10; i++) send_item(OP_ADD, mesh_vtx());
    drain();
  endtask

  task automatic test_random();
    for (int i = 0; i < 330; i++) begin
      int r;
      r = $urandom_range(99);
      if (r < 2) send_item(OP_BATCH, rand_vtx());
      else if (r < 45) send_item(OP_ADD, mesh_vtx());
      else if (r < 70 && seen_q.size() > 0)
        send_item(OP_ADD, seen_q[$urandom_range(seen_q.size() - 1)]);
      else send_item(OP_ADD, rand_vtx());
      if (seen_q.size() > 200) seen_q.delete(0);
    end
    drain();
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 60; i++) send_item(OP_ADD, mesh_vtx());
    idle_pct = 28;
    stall_pct = 28;
    drain();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_out = 1;
    fork
      for (int i = 0; i < 8; i++) send_item(OP_ADD, mesh_vtx());
      repeat (400) @(posedge clk);
    join_any
    hold_out = 0;
    wait fork;
    drain();
  endtask

  initial begin
    rst = 1;
    in_valid = 0; op = OP_ADD;
    pos_x = 0; pos_y = 0; pos_z = 0; color_rgba = 0;
    normal_x = 0; normal_y = 0; normal_z = 0; tex_u = 0; tex_v = 0; tex_slot = 0;
    foreach (bkt_used[i]) bkt_used[i] = 0;
    nverts = 0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 0;
    test_directed();
    test_random();
    test_no_idle();
    test_backpressure();
    test_random();
    drain();
    $display("covered %0d transfers: %0d new, %0d repeats found, %0d full",
             n_sent, n_new, n_hit, n_full);
    $display("results checked: %0d, mismatches: %0d", n_checked, errors);
    if (errors == 0 && expected_q.size() == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end
endmodule
